// ===== sv/stfth_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STFT Hann analysis package
// Shared widths, the sequencer state type and the engine control struct.
// ----------------------------------------------------------------------------
package stfth_pkg;

  localparam int SAMPLE_W = 16;
  localparam int HOP_W    = 7;
  localparam int BIN_W    = 6;
  localparam int PART_W   = 23;
  localparam int IDX_W    = 6;
  localparam int ACC_W    = 39;

  localparam logic [HOP_W-1:0] HOP_RESET = 7'd32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WIN,
    ST_DFT,
    ST_OUT
  } stfth_state_e;

  // Control for the engine, aligned with the memory read data.
  typedef struct packed {
    logic             win;
    logic             dft;
    logic             clr;
    logic [IDX_W-1:0] idx;
  } stfth_ctl_t;

endpackage

// ===== sv/stft_hann_analysis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STFT Hann analysis
// Short-time Fourier analysis with a periodic Hann window and a direct DFT.
// ----------------------------------------------------------------------------
// Samples enter one item at a time into a ring memory of FRAME entries. Once
// FRAME samples of a signal have arrived, and every hop samples after that,
// the block stops taking samples and works on the frame: a window pass reads
// the ring oldest first, multiplies each sample by the Hann coefficient and
// stores the Q1.15 result in a second memory.
// Then, for each bin 0..FRAME/2, one complex multiply-accumulate unit walks
// the windowed memory at one read per cycle and then loads the output
// register; a finished bin waits until the previous one was taken from the
// output register. That single memory read port sets the throughput. A
// sample that does not complete a frame leaves the block idle and ready for
// the next sample.
// A sample marked last still counts and may fire a frame; the next sample
// starts a new signal. The hop register may be written while the block is
// idle; zero acts as one, and the value takes effect when the next frame
// fires. The ring needs no clearing since a frame never reads stale entries.
// ----------------------------------------------------------------------------
module stft_hann_analysis #(
  parameter int FRAME = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [stfth_pkg::HOP_W-1:0]           cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [stfth_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                  last_sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [stfth_pkg::BIN_W-1:0]           bin_number_o,
  output logic signed [stfth_pkg::PART_W-1:0]   real_part_o,
  output logic signed [stfth_pkg::PART_W-1:0]   imag_part_o,
  output logic                                  frame_done_o
);
  import stfth_pkg::*;

  localparam int AW = $clog2(FRAME);
  localparam int CW = AW + 1;
  localparam int NB = FRAME / 2 + 1;
  localparam logic [CW-1:0] FRAME_C = CW'(FRAME);
  localparam logic [CW-1:0] LAST_BIN = CW'(NB - 1);

  stfth_state_e state_q, state_d;

  logic [HOP_W-1:0] hop_q, hop_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [HOP_W-1:0] hcd_q, hcd_d;
  logic [AW-1:0]    wp_q, wp_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    tw_q, tw_d;
  logic [CW-1:0]    k_q, k_d;
  logic             s1_q, s1_d, s2_q;
  logic [AW-1:0]    s1_idx_q, s1_idx_d, s2_idx_q;
  logic             out_vld_q, out_vld_d;
  logic [BIN_W-1:0] out_bin_q;
  logic signed [PART_W-1:0] out_re_q, out_im_q;
  logic             out_done_q;

  logic in_acc, out_acc, fire, issue, drained, load_out;
  logic [CW-1:0]   fill_inc;
  logic [HOP_W-1:0] hop_m1;
  logic [CW-1:0]   ring_sum, tw_sum;
  logic [AW-1:0]   ring_raddr;
  logic signed [SAMPLE_W-1:0] ring_rdata, vbuf_rdata, rd_data, win_val;
  logic signed [PART_W-1:0]   bin_re, bin_im;
  stfth_ctl_t ctl;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);

  // Frame timing per accepted sample.
  assign fill_inc = (fill_q < FRAME_C) ? fill_q + 1'b1 : fill_q;
  assign hop_m1   = (hop_q == '0) ? '0 : hop_q - 1'b1;
  assign fire     = in_acc && (fill_inc == FRAME_C) && (hcd_q == '0);

  assign issue    = (state_q == ST_WIN || state_q == ST_DFT) && (cnt_q < FRAME_C);
  assign drained  = (cnt_q == FRAME_C) && !s1_q && !s2_q;
  assign load_out = (state_q == ST_OUT) && (!out_vld_q || out_acc);

  assign ring_sum   = CW'(wp_q) + cnt_q;
  assign ring_raddr = (ring_sum >= FRAME_C) ? AW'(ring_sum - FRAME_C) : AW'(ring_sum);
  assign tw_sum     = tw_q + k_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (fire) state_d = ST_WIN;
      ST_WIN:  if (drained) state_d = ST_DFT;
      ST_DFT:  if (drained) state_d = ST_OUT;
      ST_OUT: begin
        if (load_out) state_d = (k_q == LAST_BIN) ? ST_IDLE : ST_DFT;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Counters, pointers and output register control.
  always_comb begin
    hop_d     = cfg_valid_i ? cfg_data_i : hop_q;
    fill_d    = fill_q;
    hcd_d     = hcd_q;
    wp_d      = wp_q;
    cnt_d     = cnt_q;
    tw_d      = tw_q;
    k_d       = k_q;
    s1_d      = issue;
    s1_idx_d  = (state_q == ST_WIN) ? cnt_q[AW-1:0] : tw_q[AW-1:0];
    out_vld_d = out_vld_q && !out_acc;
    if (in_acc) begin
      wp_d = (wp_q == AW'(FRAME - 1)) ? '0 : wp_q + 1'b1;
      if (fill_inc == FRAME_C) hcd_d = fire ? hop_m1 : hcd_q - 1'b1;
      fill_d = fill_inc;
      if (last_sample_i) begin
        fill_d = '0;
        hcd_d  = '0;
      end
    end
    if (issue) begin
      cnt_d = cnt_q + 1'b1;
      tw_d  = (tw_sum >= FRAME_C) ? tw_sum - FRAME_C : tw_sum;
    end
    if (fire) cnt_d = '0;
    if (state_q == ST_WIN && drained) begin
      cnt_d = '0;
      tw_d  = '0;
      k_d   = '0;
    end
    if (load_out) begin
      out_vld_d = 1'b1;
      cnt_d     = '0;
      tw_d      = '0;
      k_d       = k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      hop_q     <= HOP_RESET;
      fill_q    <= '0;
      hcd_q     <= '0;
      wp_q      <= '0;
      cnt_q     <= '0;
      tw_q      <= '0;
      k_q       <= '0;
      s1_q      <= 1'b0;
      s2_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      hop_q     <= hop_d;
      fill_q    <= fill_d;
      hcd_q     <= hcd_d;
      wp_q      <= wp_d;
      cnt_q     <= cnt_d;
      tw_q      <= tw_d;
      k_q       <= k_d;
      s1_q      <= s1_d;
      s2_q      <= s1_q;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= s1_idx_d;
    s2_idx_q <= s1_idx_q;
    if (load_out) begin
      out_bin_q  <= BIN_W'(k_q);
      out_re_q   <= bin_re;
      out_im_q   <= bin_im;
      out_done_q <= (k_q == LAST_BIN);
    end
  end

  stfth_ram #(.WIDTH(SAMPLE_W), .DEPTH(FRAME)) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (wp_q),
    .wdata_i (sample_i),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  stfth_ram #(.WIDTH(SAMPLE_W), .DEPTH(FRAME)) u_vbuf (
    .clk_i   (clk_i),
    .we_i    (s2_q && state_q == ST_WIN),
    .waddr_i (s2_idx_q),
    .wdata_i (win_val),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (vbuf_rdata)
  );

  assign rd_data = (state_q == ST_WIN) ? ring_rdata : vbuf_rdata;

  always_comb begin
    ctl.win = s1_q && (state_q == ST_WIN);
    ctl.dft = s1_q && (state_q == ST_DFT);
    ctl.clr = (state_q == ST_DFT) && (cnt_q == '0) && !s1_q && !s2_q;
    ctl.idx = IDX_W'(s1_idx_q);
  end

  stfth_engine #(.FRAME(FRAME)) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .rd_data_i (rd_data),
    .win_val_o (win_val),
    .re_o      (bin_re),
    .im_o      (bin_im)
  );

  assign out_valid_o  = out_vld_q;
  assign bin_number_o = out_bin_q;
  assign real_part_o  = out_re_q;
  assign imag_part_o  = out_im_q;
  assign frame_done_o = out_done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FRAME_C)
    else $error("fill count ran past the frame length");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> state_q == ST_WIN)
    else $error("frame fired without starting the window pass");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> k_q <= LAST_BIN)
    else $error("bin index beyond the last bin");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> state_q != ST_IDLE && state_q != ST_OUT)
    else $error("memory read issued outside a pass");

endmodule

// ===== sv/stfth_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STFT generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module stfth_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/stfth_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STFT arithmetic engine
// Window and twiddle tables, the window multiplier and the complex MAC.
// ----------------------------------------------------------------------------
module stfth_engine #(
  parameter int FRAME = 64
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  stfth_pkg::stfth_ctl_t                   ctl_i,
  input  logic signed [stfth_pkg::SAMPLE_W-1:0]   rd_data_i,
  output logic signed [stfth_pkg::SAMPLE_W-1:0]   win_val_o,
  output logic signed [stfth_pkg::PART_W-1:0]     re_o,
  output logic signed [stfth_pkg::PART_W-1:0]     im_o
);
  import stfth_pkg::*;

  localparam int AW = $clog2(FRAME);
  localparam longint HALF_FRAME = FRAME / 2;
  localparam longint TWO_FRAME  = 2 * FRAME;
  localparam longint FOUR_FRAME = 4 * FRAME;
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint unsigned DIVS [20] = '{1, 2, 12, 30, 56, 90, 132, 182, 240, 306,
                                             380, 462, 552, 650, 756, 870, 992, 1122,
                                             1260, 1406};

  // cos(pi*p/q) in Q30 where q is FRAME, or 2*FRAME when dbl is set.
  function automatic longint cos_pi(input longint p, input bit dbl);
    longint q;
    longint m;
    longint sum;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    bit neg;
    q = dbl ? TWO_FRAME : longint'(FRAME);
    m = dbl ? p % FOUR_FRAME : p % TWO_FRAME;
    neg = 1'b0;
    if (m < 0) m = m + 2 * q;
    if (m > q) m = 2 * q - m;
    if (2 * m > q) begin
      m = q - m;
      neg = 1'b1;
    end
    if (dbl) x = (PI_Q30 * longint'(m) + FRAME) / TWO_FRAME;
    else     x = (PI_Q30 * longint'(m) + HALF_FRAME) / FRAME;
    x2 = (x * x) >> 30;
    term = ONE_Q30;
    sum = ONE_Q30;
    for (int k = 1; k < 20; k++) begin
      if (term != 0) begin
        term = ((term * x2) >> 30) / DIVS[k];
        if (k[0]) sum = sum - longint'(term);
        else      sum = sum + longint'(term);
      end
    end
    return neg ? -sum : sum;
  endfunction

  function automatic longint win_of(input longint i);
    longint d;
    d = ONE_Q30 - cos_pi(2 * i, 1'b0);
    if (d < 0) d = 0;
    return (d + 16384) >>> 15;
  endfunction

  function automatic longint q15_of(input longint c);
    longint t;
    t = ((c + 2 * ONE_Q30 + 16384) >>> 15) - 65536;
    if (t < -32768) t = -32768;
    if (t > 32767) t = 32767;
    return t;
  endfunction

  logic        [16:0]         win_tab [FRAME];
  logic signed [SAMPLE_W-1:0] cos_tab [FRAME];
  logic signed [SAMPLE_W-1:0] sin_tab [FRAME];

  for (genvar g = 0; g < FRAME; g++) begin : g_tab
    assign win_tab[g] = 17'(win_of(longint'(g)));
    assign cos_tab[g] = 16'(q15_of(cos_pi(2 * longint'(g), 1'b0)));
    assign sin_tab[g] = 16'(q15_of(cos_pi(longint'(FRAME) - 4 * longint'(g), 1'b1)));
  end

  logic [AW-1:0] tidx;
  assign tidx = ctl_i.idx[AW-1:0];

  logic signed [33:0]      win_prod_q;
  logic signed [31:0]      re_prod_q, im_prod_q;
  logic                    mac_vld_q;
  logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
  logic signed [33:0]      win_rnd;
  logic signed [ACC_W-1:0] re_rnd, im_rnd;

  always_ff @(posedge clk_i) begin
    win_prod_q <= rd_data_i * $signed({1'b0, win_tab[tidx]});
    re_prod_q  <= rd_data_i * cos_tab[tidx];
    im_prod_q  <= rd_data_i * sin_tab[tidx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_vld_q <= 1'b0;
      acc_re_q  <= '0;
      acc_im_q  <= '0;
    end else begin
      mac_vld_q <= ctl_i.dft;
      if (ctl_i.clr) begin
        acc_re_q <= '0;
        acc_im_q <= '0;
      end else if (mac_vld_q) begin
        acc_re_q <= acc_re_q + ACC_W'(re_prod_q);
        acc_im_q <= acc_im_q - ACC_W'(im_prod_q);
      end
    end
  end

  assign win_rnd   = win_prod_q + 34'sd32768;
  assign win_val_o = win_rnd[31:16];
  assign re_rnd    = acc_re_q + ACC_W'(16384);
  assign im_rnd    = acc_im_q + ACC_W'(16384);
  assign re_o      = re_rnd[37:15];
  assign im_o      = im_rnd[37:15];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.win && ctl_i.dft))
    else $error("engine asked for window and transform at once");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clr |-> !mac_vld_q)
    else $error("accumulator cleared while a product is pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.dft |=> mac_vld_q)
    else $error("transform product lost");

endmodule
